>>> rtl/keyed_part_table_assert.svh
// assertion macros for the keyed part table
`ifndef KEYED_PART_TABLE_ASSERT_SVH
`define KEYED_PART_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define KPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KPT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/kpt_pkg.sv
package kpt_pkg;

	localparam int NAME_BYTES = 20;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_PRESENT   = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	function automatic logic [63:0] byte_mask(input int first, input int count);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < count; b++) begin
			if (first + b < NAME_BYTES) begin
				m[8*b +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	localparam logic [63:0] NAME_LOW_MASK  = byte_mask(0, 8);
	localparam logic [63:0] NAME_MID_MASK  = byte_mask(8, 8);
	localparam logic [63:0] NAME_HIGH_MASK = byte_mask(16, 4);

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] name_low;
		logic [63:0] name_mid;
		logic [31:0] name_high;
		logic [31:0] quantity;
	} entry_t;

	typedef struct packed {
		logic   hit;
		entry_t recirc;
	} head_t;

endpackage

>>> rtl/kpt_cell.sv
module kpt_cell (
	input  logic            clk,
	input  logic            shift,
	input  kpt_pkg::entry_t shift_in,
	input  logic            load,
	input  kpt_pkg::entry_t load_in,
	output kpt_pkg::entry_t data
);

	kpt_pkg::entry_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_in;
		end else if (shift) begin
			data_q <= shift_in;
		end
	end

	assign data = data_q;

endmodule

>>> rtl/kpt_head.sv
module kpt_head (
	input  kpt_pkg::entry_t cur,
	input  logic            valid_entry,
	input  logic [1:0]      opcode,
	input  logic [31:0]     part_key,
	input  logic [31:0]     amount,
	output kpt_pkg::head_t  head
);

	logic [32:0] sum;
	logic [31:0] sat;
	logic        hit;

	assign sum = {cur.quantity[31], cur.quantity} + {amount[31], amount};

	always_comb begin
		if (sum[32] != sum[31]) begin
			sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			sat = sum[31:0];
		end
	end

	assign hit = valid_entry && (cur.key == part_key);

	always_comb begin
		head.hit    = hit;
		head.recirc = cur;
		if (hit && opcode == kpt_pkg::OP_UPDATE) begin
			head.recirc.quantity = sat;
		end
	end

endmodule

>>> rtl/keyed_part_table.sv
// Linear-search part table. Each item inserts, searches or adds a saturating signed delta to
// the quantity of an entry, keyed by a 32-bit part number, and gives exactly one result item
// with a status and the entry's name and quantity. Entries live in a ring of TABLE_DEPTH cells
// that rotates once per item, so every entry passes the single compare and add head once. The
// scan steps the ring once per cell, then the S_FINISH state registers the result, and waits
// there while the output is held; a new item is accepted only back in S_IDLE, once the result
// of the previous item has been registered.
// A new item may be accepted while the previous result still waits on the output. The table
// needs no clearing after reset: of the table's state only the fill count is reset, and entries
// at or above it are never looked at.
module keyed_part_table #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] part_key,
	input  logic [63:0]        name_low,
	input  logic [63:0]        name_mid,
	input  logic [31:0]        name_high,
	input  logic signed [31:0] amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [63:0]        found_name_low,
	output logic [63:0]        found_name_mid,
	output logic [31:0]        found_name_high,
	output logic signed [31:0] found_quantity
);

	`include "keyed_part_table_assert.svh"

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic [CW-1:0] fill_q;
	logic          found_q;
	logic          out_valid_q;

	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic [63:0] name_low_q;
	logic [63:0] name_mid_q;
	logic [31:0] name_high_q;
	logic [31:0] amount_q;

	logic [63:0] res_name_low_q;
	logic [63:0] res_name_mid_q;
	logic [31:0] res_name_high_q;
	logic [31:0] res_quantity_q;

	logic [1:0]  status_q;
	logic [63:0] out_name_low_q;
	logic [63:0] out_name_mid_q;
	logic [31:0] out_name_high_q;
	logic [31:0] out_quantity_q;

	kpt_pkg::entry_t cell_data [TABLE_DEPTH];
	kpt_pkg::entry_t new_entry;
	kpt_pkg::head_t  head;

	logic in_acc;
	logic scanning;
	logic last;
	logic in_range;
	logic full;
	logic fin_go;
	logic ins_ok;

	logic [1:0]  st_d;
	logic [63:0] nl_d;
	logic [63:0] nm_d;
	logic [31:0] nh_d;
	logic [31:0] q_d;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign scanning = (state_q == S_SCAN);
	assign last     = (cnt_q == IW'(TABLE_DEPTH - 1));
	assign in_range = (CW'(cnt_q) < fill_q);
	assign full     = (fill_q >= CW'(TABLE_DEPTH));
	assign fin_go   = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign ins_ok   = (op_q == kpt_pkg::OP_INSERT) && !full && !found_q;

	assign new_entry.key       = key_q;
	assign new_entry.name_low  = name_low_q & kpt_pkg::NAME_LOW_MASK;
	assign new_entry.name_mid  = name_mid_q & kpt_pkg::NAME_MID_MASK;
	assign new_entry.name_high = name_high_q & kpt_pkg::NAME_HIGH_MASK[31:0];
	assign new_entry.quantity  = amount_q;

	kpt_head u_head (
		.cur         (cell_data[0]),
		.valid_entry (in_range),
		.opcode      (op_q),
		.part_key    (key_q),
		.amount      (amount_q),
		.head        (head)
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		kpt_pkg::entry_t nxt;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nxt = head.recirc;
		end else begin : g_body
			assign nxt = cell_data[i + 1];
		end
		kpt_cell u_cell (
			.clk      (clk),
			.shift    (scanning),
			.shift_in (nxt),
			.load     (fin_go && ins_ok && (fill_q == CW'(i))),
			.load_in  (new_entry),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (head.hit) begin
						found_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (ins_ok) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q        <= opcode;
			key_q       <= part_key;
			name_low_q  <= name_low;
			name_mid_q  <= name_mid;
			name_high_q <= name_high;
			amount_q    <= amount;
		end
		if (scanning && head.hit) begin
			res_name_low_q  <= head.recirc.name_low;
			res_name_mid_q  <= head.recirc.name_mid;
			res_name_high_q <= head.recirc.name_high;
			res_quantity_q  <= head.recirc.quantity;
		end
	end

	always_comb begin
		st_d = kpt_pkg::STAT_NOT_FOUND;
		nl_d = '0;
		nm_d = '0;
		nh_d = '0;
		q_d  = '0;
		case (op_q)
			kpt_pkg::OP_INSERT: begin
				if (full) begin
					st_d = kpt_pkg::STAT_FULL;
				end else if (found_q) begin
					st_d = kpt_pkg::STAT_PRESENT;
				end else begin
					st_d = kpt_pkg::STAT_OK;
					nl_d = new_entry.name_low;
					nm_d = new_entry.name_mid;
					nh_d = new_entry.name_high;
					q_d  = new_entry.quantity;
				end
			end
			kpt_pkg::OP_SEARCH, kpt_pkg::OP_UPDATE: begin
				if (found_q) begin
					st_d = kpt_pkg::STAT_OK;
					nl_d = res_name_low_q;
					nm_d = res_name_mid_q;
					nh_d = res_name_high_q;
					q_d  = res_quantity_q;
				end
			end
			default: begin
				st_d = kpt_pkg::STAT_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q        <= st_d;
			out_name_low_q  <= nl_d;
			out_name_mid_q  <= nm_d;
			out_name_high_q <= nh_d;
			out_quantity_q  <= q_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign found_name_low  = out_name_low_q;
	assign found_name_mid  = out_name_mid_q;
	assign found_name_high = out_name_high_q;
	assign found_quantity  = out_quantity_q;

	`KPT_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(TABLE_DEPTH))
	`KPT_ASSERT_NXT(a_accept_scan, clk, arst_n, in_acc, state_q == S_SCAN && cnt_q == '0)
	`KPT_ASSERT_NXT(a_fill_hold, clk, arst_n, state_q != S_FINISH, $stable(fill_q))
	`KPT_ASSERT_NXT(a_out_source, clk, arst_n, !out_valid_q && state_q != S_FINISH, !out_valid_q)

endmodule
